// ===== design/mef_pkg.sv =====
// Shared constants, types and register codes for the median/average level filter.
package mef_pkg;

	localparam int WINDOW_SIZE = 5;
	localparam int SAMPLE_W    = 16;
	localparam int AVG_W       = 24;
	localparam int WEIGHT_W    = 9;
	localparam int RATIO_W     = 16;
	localparam int FRAC_W      = 8;

	localparam int POS_W       = $clog2(WINDOW_SIZE);
	localparam int CNT_W       = $clog2(WINDOW_SIZE + 1);
	localparam int MEDIAN_RANK = WINDOW_SIZE / 2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int DIV_STEPS   = 16;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;

	localparam logic [1:0] REG_EMPTY  = 2'd0;
	localparam logic [1:0] REG_FULL   = 2'd1;
	localparam logic [1:0] REG_WEIGHT = 2'd2;

	localparam logic [SAMPLE_W-1:0] EMPTY_RST  = 16'd2400;
	localparam logic [SAMPLE_W-1:0] FULL_RST   = 16'd330;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 9'd51;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;
	localparam logic [RATIO_W-1:0]  RATIO_ONE  = 16'd32768;

	typedef struct packed {
		logic [SAMPLE_W-1:0] value;
		logic                filtered;
	} mef_item_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] empty_res;
		logic [SAMPLE_W-1:0] full_res;
		logic [WEIGHT_W-1:0] weight;
	} mef_cfg_t;

endpackage

// ===== design/mef_front.sv =====
// Front end: sample window, fill tracking and median search.
module mef_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [mef_pkg::SAMPLE_W-1:0] resistance_sample,
	input  logic                         queue_full,
	output logic                         push,
	output mef_pkg::mef_item_t           push_item
);
	import mef_pkg::*;

	localparam logic F_IDLE = 1'b0;
	localparam logic F_MED  = 1'b1;

	logic                state_q;
	logic [SAMPLE_W-1:0] win_q [WINDOW_SIZE];
	logic [POS_W-1:0]    wpos_q;
	logic [CNT_W-1:0]    seen_q;
	logic [POS_W-1:0]    cand_q;

	logic                accept;
	logic                will_fill;
	logic [SAMPLE_W-1:0] cand;
	logic [CNT_W-1:0]    lt_cnt;
	logic [CNT_W-1:0]    le_cnt;
	logic                found;

	assign in_ready  = (state_q == F_IDLE) && !queue_full;
	assign accept    = in_valid && in_ready;
	assign will_fill = seen_q >= CNT_W'(WINDOW_SIZE - 1);
	assign cand      = win_q[cand_q];

	// rank of the current candidate within the window
	always_comb begin
		lt_cnt = '0;
		le_cnt = '0;
		for (int j = 0; j < WINDOW_SIZE; j++) begin
			if (win_q[j] < cand)
				lt_cnt = lt_cnt + CNT_W'(1);
			if (win_q[j] <= cand)
				le_cnt = le_cnt + CNT_W'(1);
		end
	end

	assign found = (lt_cnt <= CNT_W'(MEDIAN_RANK)) && (le_cnt > CNT_W'(MEDIAN_RANK));

	assign push               = (accept && !will_fill) || (state_q == F_MED && found);
	assign push_item.value    = (state_q == F_MED) ? cand : resistance_sample;
	assign push_item.filtered = (state_q == F_MED);

	always_ff @(posedge clk) begin
		if (accept)
			win_q[wpos_q] <= resistance_sample;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			wpos_q  <= '0;
			seen_q  <= '0;
			cand_q  <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						wpos_q <= (wpos_q == POS_W'(WINDOW_SIZE - 1)) ? '0 : wpos_q + POS_W'(1);
						if (seen_q < CNT_W'(WINDOW_SIZE))
							seen_q <= seen_q + CNT_W'(1);
						if (will_fill) begin
							state_q <= F_MED;
							cand_q  <= '0;
						end
					end
				end
				F_MED: begin
					if (found)
						state_q <= F_IDLE;
					else
						cand_q <= cand_q + POS_W'(1);
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

// ===== design/mef_queue.sv =====
// Short item queue between the front end and the back end.
module mef_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  mef_pkg::mef_item_t push_item,
	output logic               full,
	input  logic               pop,
	output mef_pkg::mef_item_t pop_item,
	output logic               empty
);
	import mef_pkg::*;

	mef_item_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full     = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
			if (pop)
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

endmodule

// ===== design/mef_back.sv =====
// Back end: exponential average, calibration map, serial divide and output register.
module mef_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mef_pkg::mef_cfg_t           cfg,
	input  logic                        queue_empty,
	input  mef_pkg::mef_item_t          pop_item,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [mef_pkg::RATIO_W-1:0] fill_ratio,
	output logic                        is_filtered
);
	import mef_pkg::*;

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_MUL  = 3'd1;
	localparam logic [2:0] B_SUM  = 3'd2;
	localparam logic [2:0] B_PREP = 3'd3;
	localparam logic [2:0] B_DIV  = 3'd4;
	localparam logic [2:0] B_OUT  = 3'd5;

	localparam int PA_W  = WEIGHT_W + SAMPLE_W;
	localparam int PB_W  = WEIGHT_W + AVG_W;
	localparam int ACC_W = PB_W + 1;
	localparam int NUM_W = AVG_W + 1;
	localparam int DIF_W = SAMPLE_W + 1;
	localparam int DVD_W = AVG_W + DIV_STEPS;

	logic [2:0]           state_q;
	logic                 started_q;
	logic [AVG_W-1:0]     avg_q;
	logic [AVG_W-1:0]     value_q;
	logic [SAMPLE_W-1:0]  med_q;
	logic                 filt_q;
	logic [PA_W-1:0]      prod_a_q;
	logic [PB_W-1:0]      prod_b_q;
	logic [AVG_W-1:0]     rem_q;
	logic [AVG_W-1:0]     ad_q;
	logic [DIV_STEPS-1:0] dlow_q;
	logic [RATIO_W-1:0]   quo_q;
	logic [DIV_CNT_W-1:0] step_q;
	logic                 out_valid_q;
	logic [RATIO_W-1:0]   fill_ratio_q;
	logic                 is_filtered_q;

	logic [WEIGHT_W-1:0]  w_c;
	logic [ACC_W-1:0]     acc;
	logic [NUM_W-1:0]     num;
	logic [DIF_W-1:0]     dif;
	logic                 num_neg;
	logic                 den_neg;
	logic [AVG_W-1:0]     an;
	logic [AVG_W-1:0]     ad;
	logic [DVD_W-1:0]     dvd;
	logic [AVG_W:0]       trial;
	logic [AVG_W:0]       trial_sub;
	logic                 qbit;
	logic                 load_out;

	assign w_c = (cfg.weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.weight;
	assign acc = ACC_W'({prod_a_q, {FRAC_W{1'b0}}}) + ACC_W'(prod_b_q) + ACC_W'(128);

	assign num     = {1'b0, value_q} - {1'b0, cfg.empty_res, {FRAC_W{1'b0}}};
	assign dif     = {1'b0, cfg.full_res} - {1'b0, cfg.empty_res};
	assign num_neg = num[NUM_W-1];
	assign den_neg = dif[DIF_W-1];
	always_comb begin
		logic [NUM_W-1:0] num_abs;
		logic [DIF_W-1:0] dif_abs;
		num_abs = num_neg ? (~num + NUM_W'(1)) : num;
		dif_abs = den_neg ? (~dif + DIF_W'(1)) : dif;
		an      = num_abs[AVG_W-1:0];
		ad      = {dif_abs[SAMPLE_W-1:0], {FRAC_W{1'b0}}};
	end
	// rounded dividend: an * 2^15 + ad / 2
	assign dvd = DVD_W'({an, 15'b0}) + DVD_W'(ad >> 1);

	assign trial     = {rem_q, dlow_q[DIV_STEPS-1]};
	assign trial_sub = trial - {1'b0, ad_q};
	assign qbit      = trial >= {1'b0, ad_q};

	assign pop      = (state_q == B_IDLE) && !queue_empty;
	assign load_out = (state_q == B_OUT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (pop) begin
					filt_q  <= pop_item.filtered;
					med_q   <= pop_item.value;
					value_q <= {pop_item.value, {FRAC_W{1'b0}}};
				end
			end
			B_MUL: begin
				prod_a_q <= PA_W'(w_c) * PA_W'(med_q);
				prod_b_q <= PB_W'(WEIGHT_ONE - w_c) * PB_W'(avg_q);
			end
			B_SUM: begin
				value_q <= acc[AVG_W+FRAC_W-1:FRAC_W];
			end
			B_PREP: begin
				if (dif == '0 || num == '0 || num_neg != den_neg)
					quo_q <= '0;
				else if (an >= ad)
					quo_q <= RATIO_ONE;
				else
					quo_q <= '0;
				rem_q  <= dvd[DVD_W-1:DIV_STEPS];
				dlow_q <= dvd[DIV_STEPS-1:0];
				ad_q   <= ad;
			end
			B_DIV: begin
				if (qbit)
					rem_q <= trial_sub[AVG_W-1:0];
				else
					rem_q <= trial[AVG_W-1:0];
				dlow_q <= {dlow_q[DIV_STEPS-2:0], 1'b0};
				quo_q  <= {quo_q[RATIO_W-2:0], qbit};
			end
			B_OUT: begin
				if (load_out) begin
					fill_ratio_q  <= quo_q;
					is_filtered_q <= filt_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			started_q   <= 1'b0;
			avg_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				B_IDLE: begin
					if (pop) begin
						if (!pop_item.filtered) begin
							state_q <= B_PREP;
						end else if (!started_q) begin
							// seed: the average starts at this median and no update is run for this item
							avg_q     <= {pop_item.value, {FRAC_W{1'b0}}};
							started_q <= 1'b1;
							state_q   <= B_PREP;
						end else begin
							state_q <= B_MUL;
						end
					end
				end
				B_MUL: state_q <= B_SUM;
				B_SUM: begin
					avg_q   <= acc[AVG_W+FRAC_W-1:FRAC_W];
					state_q <= B_PREP;
				end
				B_PREP: begin
					step_q <= '0;
					if (dif == '0 || num == '0 || num_neg != den_neg || an >= ad)
						state_q <= B_OUT;
					else
						state_q <= B_DIV;
				end
				B_DIV: begin
					step_q <= step_q + DIV_CNT_W'(1);
					if (step_q == DIV_CNT_W'(DIV_STEPS - 1))
						state_q <= B_OUT;
				end
				B_OUT: begin
					if (load_out)
						state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign fill_ratio  = fill_ratio_q;
	assign is_filtered = is_filtered_q;

	a_ratio_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> fill_ratio_q <= RATIO_ONE)
		else $error("fill ratio above one");

	a_started_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |=> started_q)
		else $error("average seed flag dropped");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_DIV |-> rem_q < ad_q)
		else $error("divider remainder out of range");

	a_filtered_needs_seed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_MUL) |-> started_q)
		else $error("average update before seed");

endmodule

// ===== design/median_ema_level_filter.sv =====
// Top level of the median/average level filter with its APB register file.
//
// One resistance sample in, one Q1.15 fill ratio out. The front end writes the
// sample into a five-entry ring window and, once the window is full, searches
// the median one candidate per cycle. Items then pass a two-entry queue to the
// back end, which runs the average update for filtered items, the calibration
// map, a 16-step serial divide where the ratio is not clamped and the output
// register, with front and back overlapping through the queue. No clearing
// pass after reset. Registers: empty resistance at 0x0, full resistance at
// 0x4, smoothing weight at 0x8; write them only while no item is in flight.
module median_ema_level_filter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mef_pkg::ADDR_W-1:0]   paddr,
	input  logic [mef_pkg::DATA_W-1:0]   pwdata,
	output logic [mef_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [mef_pkg::SAMPLE_W-1:0] resistance_sample,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mef_pkg::RATIO_W-1:0]  fill_ratio,
	output logic                         is_filtered
);
	import mef_pkg::*;

	mef_cfg_t  cfg_q;
	mef_item_t push_item;
	mef_item_t pop_item;
	logic      push;
	logic      pop;
	logic      queue_full;
	logic      queue_empty;
	logic      wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.empty_res <= EMPTY_RST;
			cfg_q.full_res  <= FULL_RST;
			cfg_q.weight    <= WEIGHT_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_EMPTY:  cfg_q.empty_res <= pwdata[SAMPLE_W-1:0];
				REG_FULL:   cfg_q.full_res  <= pwdata[SAMPLE_W-1:0];
				REG_WEIGHT: cfg_q.weight    <= pwdata[WEIGHT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_EMPTY:  prdata = DATA_W'(cfg_q.empty_res);
			REG_FULL:   prdata = DATA_W'(cfg_q.full_res);
			REG_WEIGHT: prdata = DATA_W'(cfg_q.weight);
			default:    prdata = '0;
		endcase
	end

	mef_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.resistance_sample (resistance_sample),
		.queue_full        (queue_full),
		.push              (push),
		.push_item         (push_item)
	);

	mef_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (queue_empty)
	);

	mef_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.queue_empty (queue_empty),
		.pop_item    (pop_item),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.fill_ratio  (fill_ratio),
		.is_filtered (is_filtered)
	);

endmodule

// ===== tb/level_filter_checker.sv =====
`timescale 1ns / 100ps
// Checker for the level filter: follows register writes, predicts each fill ratio, compares.
module level_filter_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mef_pkg::ADDR_W-1:0]   paddr,
	input  logic [mef_pkg::DATA_W-1:0]   pwdata,
	input  logic                         pready,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [mef_pkg::SAMPLE_W-1:0] resistance_sample,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [mef_pkg::RATIO_W-1:0]  fill_ratio,
	input  logic                         is_filtered,
	output int                           mismatches,
	output int                           outstanding
);
	import mef_pkg::*;

	logic [SAMPLE_W-1:0] empty_res;
	logic [SAMPLE_W-1:0] full_res;
	logic [WEIGHT_W-1:0] weight;
	logic [SAMPLE_W-1:0] window [WINDOW_SIZE];
	int                  wr_pos;
	int                  seen;
	logic [AVG_W-1:0]    level_avg;
	logic                avg_seeded;
	mef_item_t           fill_q [$];

	task automatic report_mismatch(input string what, input int got_v, input int want_v);
		$display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got_v, want_v);
		mismatches++;
	endtask

	// Q16.8 level to Q1.15 ratio between the two calibration points
	function automatic logic [RATIO_W-1:0] ratio_of_level(input logic [AVG_W-1:0] x);
		longint num;
		longint den;
		longint an;
		longint ad;
		num = longint'(x) - longint'(empty_res) * 256;
		den = (longint'(full_res) - longint'(empty_res)) * 256;
		if (den == 0 || num == 0)
			return '0;
		if ((num < 0) != (den < 0))
			return '0;
		an = (num < 0) ? -num : num;
		ad = (den < 0) ? -den : den;
		if (an >= ad)
			return RATIO_ONE;
		return RATIO_W'(((an << 15) + ad / 2) / ad);
	endfunction

	function automatic logic [SAMPLE_W-1:0] window_median();
		logic [SAMPLE_W-1:0] s [WINDOW_SIZE];
		logic [SAMPLE_W-1:0] t;
		s = window;
		for (int i = 1; i < WINDOW_SIZE; i++)
			for (int j = i; j > 0 && s[j-1] > s[j]; j--) begin
				t = s[j];
				s[j] = s[j-1];
				s[j-1] = t;
			end
		return s[MEDIAN_RANK];
	endfunction

	function automatic mef_item_t predict_fill(input logic [SAMPLE_W-1:0] sample);
		mef_item_t           r;
		logic [SAMPLE_W-1:0] med;
		longint              w;
		longint              acc;
		window[wr_pos] = sample;
		wr_pos = (wr_pos + 1) % WINDOW_SIZE;
		if (seen < WINDOW_SIZE)
			seen++;
		if (seen < WINDOW_SIZE) begin
			r.value = ratio_of_level({sample, 8'd0});
			r.filtered = 1'b0;
			return r;
		end
		med = window_median();
		if (!avg_seeded) begin
			level_avg = {med, 8'd0};
			avg_seeded = 1'b1;
		end
		w = (weight > WEIGHT_ONE) ? 256 : longint'(weight);
		acc = w * longint'({med, 8'd0}) + (256 - w) * longint'(level_avg) + 128;
		level_avg = AVG_W'(acc >> 8);
		r.value = ratio_of_level(level_avg);
		r.filtered = 1'b1;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mef_item_t got;
		mef_item_t want;
		if (!arst_n) begin
			empty_res = EMPTY_RST;
			full_res = FULL_RST;
			weight = WEIGHT_RST;
			for (int i = 0; i < WINDOW_SIZE; i++)
				window[i] = '0;
			wr_pos = 0;
			seen = 0;
			level_avg = '0;
			avg_seeded = 1'b0;
			fill_q.delete();
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_EMPTY:  empty_res = pwdata[SAMPLE_W-1:0];
					REG_FULL:   full_res = pwdata[SAMPLE_W-1:0];
					REG_WEIGHT: weight = pwdata[WEIGHT_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				got.value = fill_ratio;
				got.filtered = is_filtered;
				if (fill_q.size() == 0) begin
					report_mismatch("unexpected item, fill_ratio", got.value, -1);
				end else begin
					want = fill_q.pop_front();
					if (got.value !== want.value)
						report_mismatch("fill_ratio", got.value, want.value);
					if (got.filtered !== want.filtered)
						report_mismatch("is_filtered", got.filtered, want.filtered);
				end
			end
			if (in_valid && in_ready)
				fill_q.push_back(predict_fill(resistance_sample));
			outstanding <= fill_q.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Testbench top for the level filter: clock, reset, register writes, samples and verdict.
module testbench;
	import mef_pkg::*;

	localparam int IDLE_PCT    = 27;
	localparam int QUIET_LIMIT = 2000;
	localparam logic [1:0] REG_SPARE = 2'd3;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid;
	logic                in_ready;
	logic [SAMPLE_W-1:0] resistance_sample;
	logic                out_valid;
	logic                out_ready;
	logic [RATIO_W-1:0]  fill_ratio;
	logic                is_filtered;
	int                  mismatches;
	int                  outstanding;
	int                  idle_pct;
	int                  quiet_cycles;

	median_ema_level_filter dut (.*);

	level_filter_checker fill_check (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .resistance_sample(resistance_sample),
		.out_valid(out_valid), .out_ready(out_ready), .fill_ratio(fill_ratio),
		.is_filtered(is_filtered),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= idle_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// all tasks start and end at a falling edge
	task automatic send_sample(input logic [SAMPLE_W-1:0] s);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		resistance_sample <= s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input int unsigned val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_calibration(input int unsigned e, input int unsigned f,
			input int unsigned w);
		drain();
		write_reg(REG_EMPTY, e);
		write_reg(REG_FULL, f);
		write_reg(REG_WEIGHT, w);
	endtask

	function automatic int unsigned pick_level();
		case ($urandom_range(4))
			0: return 0;
			1: return 65535;
			default: return $urandom_range(65535);
		endcase
	endfunction

	task automatic random_phase(input int n_items);
		int unsigned e;
		int unsigned f;
		int unsigned w;
		int unsigned lo;
		int unsigned hi;
		int unsigned span;
		e = pick_level();
		f = ($urandom_range(7) == 0) ? e : pick_level();
		case ($urandom_range(7))
			0: w = 0;
			1: w = 1;
			2: w = WEIGHT_ONE;
			3: w = $urandom_range(511, 257);
			default: w = $urandom_range(256, 1);
		endcase
		set_calibration(e, f, w);
		lo = (e < f) ? e : f;
		hi = (e < f) ? f : e;
		span = (hi - lo) / 8 + 16;
		lo = (lo > span) ? lo - span : 0;
		hi = (hi + span > 65535) ? 65535 : hi + span;
		repeat (n_items) begin
			case ($urandom_range(9))
				0: send_sample(SAMPLE_W'($urandom_range(65535)));
				1: send_sample(SAMPLE_W'($urandom_range(1) ? e : f));
				2: send_sample($urandom_range(1) ? 16'hFFFF : 16'h0000);
				default: send_sample(SAMPLE_W'($urandom_range(hi, lo)));
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		resistance_sample = '0;
		out_ready = 1'b0;
		idle_pct = IDLE_PCT;
		quiet_cycles = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// reset calibration (descending): clamps, both endpoints, then the seed
		send_sample(16'd0);
		send_sample(16'hFFFF);
		send_sample(EMPTY_RST);
		send_sample(FULL_RST);
		send_sample(16'd1000);
		send_sample(16'd1500);

		// ascending, full span, average follows the median
		set_calibration(0, 65535, WEIGHT_ONE);
		send_sample(16'hFFFF);
		send_sample(16'd0);
		send_sample(16'd32768);

		// equal calibration, frozen average
		set_calibration(1000, 1000, 0);
		send_sample(16'd500);
		send_sample(16'd1500);

		// descending full span, weight above one
		set_calibration(65535, 0, 511);
		send_sample(16'd12345);
		send_sample(16'd54321);

		// smallest weight, then a write past the register list
		set_calibration(330, 2400, 1);
		write_reg(REG_SPARE, 32'h0000_FFFF);
		send_sample(16'd0);
		send_sample(16'hFFFF);
		send_sample(16'd1000);

		for (int p = 0; p < 8; p++) begin
			drain();
			idle_pct = (p == 3) ? 0 : IDLE_PCT;
			random_phase(100);
		end

		drain();
		repeat (40) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
